// File: rtl/rsi_pkg.sv
// rsi_pkg: word types, field widths and derived datapath widths for the
// ray / sphere intersection pipeline
// no dependencies
package rsi_pkg;

  localparam int CW   = 32;  // coordinate width, signed fixed point
  localparam int FRAC = 16;  // fraction bits

  // configuration register indexes
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_CENTER_Z = 2'd2;
  localparam logic [1:0] REG_RADIUS   = 2'd3;

  // derived datapath widths
  localparam int RW     = CW - 1;          // radius
  localparam int OCW    = CW + 1;          // origin - center
  localparam int RRW    = 2 * RW;          // radius squared
  localparam int AW     = 2 * CW;          // a = d.d
  localparam int PODW   = 2 * CW + 1;      // one oc*d or oc*oc product
  localparam int DOTW   = 2 * CW + 2;      // oc.d
  localparam int OCCW   = 2 * CW + 2;      // oc.oc
  localparam int BW     = 2 * CW + 3;      // b = 2 oc.d, signed
  localparam int CBW    = 2 * CW + 3;      // c = oc.oc - r^2, signed
  localparam int BMAG   = BW - 1;          // |b|
  localparam int CMAG   = CBW - 1;         // |c|
  localparam int HB     = BMAG / 2;        // low half of |b|
  localparam int HBH    = BMAG - HB;       // high half of |b|
  localparam int AHW    = AW / 2;          // low half of a
  localparam int AHH    = AW - AHW;
  localparam int CHW    = CMAG / 2;        // low half of |c|
  localparam int CHH    = CMAG - CHW;
  localparam int B2W    = 2 * BMAG;        // b^2
  localparam int ACW    = AW + CMAG;       // a*|c|
  localparam int DW     = 4 * CW + 6;      // discriminant, signed
  localparam int RADW   = DW;              // radicand, even width
  localparam int SQW    = RADW / 2;        // root width
  localparam int SQREMW = SQW + 2;         // root remainder
  localparam int NW     = 2 * CW + 5;      // -b -/+ s, signed
  localparam int NMAG   = NW - 1;
  localparam int MAGW   = NMAG + FRAC;     // scaled magnitude
  localparam int QW     = CW + 1;          // quotient bits developed
  localparam int HIW    = MAGW - QW;       // preloaded remainder
  localparam int DENW   = AW + 1;          // 2a
  localparam int DREMW  = DENW + 1;        // division remainder

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
  } in_word_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] enter_distance;
    logic signed [CW-1:0] exit_distance;
    logic                 origin_inside;
    logic                 zero_direction;
    logic                 saturated;
  } out_word_t;

  // one square root cell's data plus the ray's sideband
  typedef struct packed {
    logic [RADW-1:0]      rad;
    logic [SQREMW-1:0]    rem;
    logic [SQW-1:0]       root;
    logic signed [BW-1:0] b;
    logic [AW-1:0]        a;
    logic                 hit;
    logic                 org_in;
    logic                 zdir;
  } sqrt_t;

  // one division cell's data
  typedef struct packed {
    logic [QW-1:0]    num;
    logic [DREMW-1:0] rem;
    logic [DENW-1:0]  den;
    logic [QW-1:0]    q;
  } div_t;

endpackage

// File: rtl/rsi_front.sv
// rsi_front: six-stage front end, products, dot sums and discriminant
// depends on rsi_pkg
module rsi_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           vld_i,
  input  rsi_pkg::in_word_t              word_i,
  input  logic signed [rsi_pkg::CW-1:0]  center_x,
  input  logic signed [rsi_pkg::CW-1:0]  center_y,
  input  logic signed [rsi_pkg::CW-1:0]  center_z,
  input  logic [rsi_pkg::RW-1:0]         radius,
  output logic                           vld_o,
  output rsi_pkg::sqrt_t                 d_o
);
  import rsi_pkg::*;

  logic [5:0] v_r;

  // stage 1: oc and r^2
  logic signed [OCW-1:0] oc1_r [3];
  logic signed [CW-1:0]  d1_r  [3];
  logic [RRW-1:0]        rr1_r;
  // stage 2: products
  logic [AW-1:0]          dd2_r [3];
  logic signed [PODW-1:0] od2_r [3];
  logic [PODW-1:0]        oo2_r [3];
  logic [RRW-1:0]         rr2_r;
  // stage 3: a, b, c
  logic [AW-1:0]         a3_r;
  logic signed [BW-1:0]  b3_r;
  logic signed [CBW-1:0] c3_r;
  logic                  z3_r, in3_r;
  // stage 4: partial products
  logic [2*HBH-1:0]     bhh4_r;
  logic [HBH+HB-1:0]    bhl4_r;
  logic [2*HB-1:0]      bll4_r;
  logic [AHH+CHH-1:0]   ahch4_r;
  logic [AHH+CHW-1:0]   ahcl4_r;
  logic [AHW+CHH-1:0]   alch4_r;
  logic [AHW+CHW-1:0]   alcl4_r;
  logic                 cs4_r, z4_r, in4_r;
  logic [AW-1:0]        a4_r;
  logic signed [BW-1:0] b4_r;
  // stage 5: b^2 and a|c|
  logic [B2W-1:0]       b25_r;
  logic [ACW-1:0]       ac5_r;
  logic                 cs5_r, z5_r, in5_r;
  logic [AW-1:0]        a5_r;
  logic signed [BW-1:0] b5_r;
  // stage 6
  sqrt_t d6_r;

  logic signed [OCW-1:0] oc_nxt [3];
  logic signed [CW-1:0]  org [3];
  logic signed [CW-1:0]  dir [3];
  logic signed [CW-1:0]  ctr [3];
  logic [OCCW-1:0]       occ;
  logic signed [DOTW-1:0] dot;
  logic signed [CBW-1:0] c_nxt;
  logic [BMAG-1:0]       bmag;
  logic [CMAG-1:0]       cmag;
  logic signed [DW-1:0]  b2s, ac4s, disc;

  assign org = '{word_i.origin_x, word_i.origin_y, word_i.origin_z};
  assign dir = '{word_i.dir_x, word_i.dir_y, word_i.dir_z};
  assign ctr = '{center_x, center_y, center_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      oc_nxt[i] = OCW'(org[i]) - OCW'(ctr[i]);
    end
  end

  always_comb begin
    occ = OCCW'(oo2_r[0]) + OCCW'(oo2_r[1]) + OCCW'(oo2_r[2]);
    dot = DOTW'(od2_r[0]) + DOTW'(od2_r[1]) + DOTW'(od2_r[2]);
    c_nxt = $signed(CBW'(occ)) - $signed(CBW'(rr2_r));
  end

  assign bmag = b3_r[BW-1] ? BMAG'(-b3_r) : BMAG'(b3_r);
  assign cmag = c3_r[CBW-1] ? CMAG'(-c3_r) : CMAG'(c3_r);

  assign b2s  = $signed(DW'(b25_r));
  assign ac4s = $signed(DW'(ac5_r) << 2);
  assign disc = b2s - (cs5_r ? -ac4s : ac4s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        oc1_r[i] <= oc_nxt[i];
        d1_r[i]  <= dir[i];
        dd2_r[i] <= AW'($unsigned(AW'(d1_r[i]) * AW'(d1_r[i])));
        od2_r[i] <= PODW'(oc1_r[i]) * PODW'(d1_r[i]);
        oo2_r[i] <= PODW'($unsigned(PODW'(oc1_r[i]) * PODW'(oc1_r[i])));
      end
      rr1_r <= RRW'(radius) * RRW'(radius);
      rr2_r <= rr1_r;

      a3_r  <= AW'(dd2_r[0]) + AW'(dd2_r[1]) + AW'(dd2_r[2]);
      b3_r  <= BW'(dot) <<< 1;
      c3_r  <= c_nxt;
      z3_r  <= (dd2_r[0] == '0) && (dd2_r[1] == '0) && (dd2_r[2] == '0);
      in3_r <= c_nxt[CBW-1] || (c_nxt == '0);

      bhh4_r  <= (2*HBH)'(bmag[BMAG-1:HB]) * (2*HBH)'(bmag[BMAG-1:HB]);
      bhl4_r  <= (HBH+HB)'(bmag[BMAG-1:HB]) * (HBH+HB)'(bmag[HB-1:0]);
      bll4_r  <= (2*HB)'(bmag[HB-1:0]) * (2*HB)'(bmag[HB-1:0]);
      ahch4_r <= (AHH+CHH)'(a3_r[AW-1:AHW]) * (AHH+CHH)'(cmag[CMAG-1:CHW]);
      ahcl4_r <= (AHH+CHW)'(a3_r[AW-1:AHW]) * (AHH+CHW)'(cmag[CHW-1:0]);
      alch4_r <= (AHW+CHH)'(a3_r[AHW-1:0]) * (AHW+CHH)'(cmag[CMAG-1:CHW]);
      alcl4_r <= (AHW+CHW)'(a3_r[AHW-1:0]) * (AHW+CHW)'(cmag[CHW-1:0]);
      cs4_r <= c3_r[CBW-1];
      z4_r  <= z3_r;
      in4_r <= in3_r;
      a4_r  <= a3_r;
      b4_r  <= b3_r;

      b25_r <= (B2W'(bhh4_r) << (2*HB)) + (B2W'(bhl4_r) << (HB+1)) + B2W'(bll4_r);
      ac5_r <= (ACW'(ahch4_r) << (AHW+CHW)) + (ACW'(ahcl4_r) << AHW)
             + (ACW'(alch4_r) << CHW) + ACW'(alcl4_r);
      cs5_r <= cs4_r;
      z5_r  <= z4_r;
      in5_r <= in4_r;
      a5_r  <= a4_r;
      b5_r  <= b4_r;

      d6_r.rad    <= RADW'($unsigned(disc));
      d6_r.rem    <= '0;
      d6_r.root   <= '0;
      d6_r.b      <= b5_r;
      d6_r.a      <= a5_r;
      d6_r.hit    <= !z5_r && !disc[DW-1];
      d6_r.org_in <= in5_r;
      d6_r.zdir   <= z5_r;
    end
  end

  assign vld_o = v_r[5];
  assign d_o   = d6_r;

endmodule

// File: rtl/rsi_sqrt_cell.sv
// rsi_sqrt_cell: one digit of the integer square root, two radicand bits a cycle while en is high
// depends on rsi_pkg
module rsi_sqrt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  rsi_pkg::sqrt_t d_i,
  output logic           vld_o,
  output rsi_pkg::sqrt_t d_o
);
  import rsi_pkg::*;

  logic [SQREMW-1:0] rem_sh, trial;
  logic              ge;
  sqrt_t             d_nxt;

  always_comb begin
    rem_sh = {d_i.rem[SQREMW-3:0], d_i.rad[RADW-1 -: 2]};
    trial  = {d_i.root, 2'b01};
    ge     = rem_sh >= trial;
    d_nxt      = d_i;
    d_nxt.rad  = d_i.rad << 2;
    d_nxt.rem  = ge ? rem_sh - trial : rem_sh;
    d_nxt.root = {d_i.root[SQW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_nxt;
    end
  end

endmodule

// File: rtl/rsi_div_cell.sv
// rsi_div_cell: one restoring division step, one quotient bit a cycle while en is high
// depends on rsi_pkg
module rsi_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  rsi_pkg::div_t d_i,
  output logic          vld_o,
  output rsi_pkg::div_t d_o
);
  import rsi_pkg::*;

  logic [DREMW-1:0] rem_sh;
  logic             ge;
  div_t             d_nxt;

  always_comb begin
    rem_sh    = {d_i.rem[DREMW-2:0], d_i.num[QW-1]};
    ge        = rem_sh >= DREMW'(d_i.den);
    d_nxt     = d_i;
    d_nxt.num = d_i.num << 1;
    d_nxt.rem = ge ? rem_sh - DREMW'(d_i.den) : rem_sh;
    d_nxt.q   = {d_i.q[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_nxt;
    end
  end

endmodule

// File: rtl/ray_sphere_intersect.sv
// ray_sphere_intersect: top level, config registers, cell chains, output register
// depends on rsi_pkg, rsi_front, rsi_sqrt_cell, rsi_div_cell
//
// One ray word enters per clock and one result word leaves per clock for each
// ray while the output register is not stalled; the pipeline then takes a new
// word even while earlier rays are in flight. From input accept to out_valid a
// word passes 6 front-end stages (oc, exact products, sums, split wide
// products, discriminant), a chain of 67 square root cells (one root bit per
// cell, RADW/2), one stage forming -b -/+ sqrt and 2a, two parallel chains of
// 33 division cells (one quotient bit per cell, CW+1) for the near and far
// distances, and the output register. All math is exact integer arithmetic, so
// results match bit for bit whatever the ray. The whole pipeline advances
// together whenever the output register is empty or being drained, so in_ready
// follows out_ready through one gate. Config registers are written on cfg_valid
// (cfg_ready is always high) and are meant to change only while no ray is in flight.
module ray_sphere_intersect (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rsi_pkg::in_word_t      in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rsi_pkg::out_word_t     out_word,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [rsi_pkg::CW-1:0] cfg_data
);
  import rsi_pkg::*;

  // sideband carried along the division chains
  typedef struct packed {
    logic hit;
    logic org_in;
    logic zdir;
    logic neg_e;
    logic neg_x;
    logic ovf_e;
    logic ovf_x;
  } side_t;

  // clip a quotient magnitude to the signed coordinate range, {sat, value}
  function automatic logic [CW:0] clip(input logic [QW-1:0] q, input logic neg,
                                       input logic ovf);
    logic          s;
    logic [CW-1:0] v;
    if (!neg) begin
      s = ovf | q[QW-1] | q[QW-2];
      v = s ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
    end else begin
      s = ovf | q[QW-1] | (q[QW-2] & (|q[QW-3:0]));
      v = s ? {1'b1, {(CW-1){1'b0}}} : CW'(-q);
    end
    return {s, v};
  endfunction

  // config registers
  logic signed [CW-1:0] center_x_r, center_y_r, center_z_r;
  logic [RW-1:0]        radius_r;

  // whole pipeline moves when the output register can take a word
  logic en;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      radius_r   <= RW'(1 << FRAC);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X: center_x_r <= cfg_data;
        REG_CENTER_Y: center_y_r <= cfg_data;
        REG_CENTER_Z: center_z_r <= cfg_data;
        REG_RADIUS:   radius_r   <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // front end: exact products down to the discriminant
  logic  sq_v [SQW+1];
  sqrt_t sq_d [SQW+1];

  rsi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_i    (in_valid && in_ready),
    .word_i   (in_word),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .center_z (center_z_r),
    .radius   (radius_r),
    .vld_o    (sq_v[0]),
    .d_o      (sq_d[0])
  );

  // square root chain
  for (genvar k = 0; k < SQW; k++) begin : g_sqrt
    rsi_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (sq_v[k]),
      .d_i   (sq_d[k]),
      .vld_o (sq_v[k+1]),
      .d_o   (sq_d[k+1])
    );
  end

  // numerators -b -/+ s, scaled, split into preloaded remainder and low bits
  sqrt_t                sq_last;
  logic signed [NW-1:0] b_w, s_w, n1, n2;
  logic [NMAG-1:0]      m1, m2;
  logic [MAGW-1:0]      sm1, sm2;
  logic [DENW-1:0]      den;
  logic                 ovf1, ovf2;

  assign sq_last = sq_d[SQW];

  always_comb begin
    b_w  = NW'(sq_last.b);
    s_w  = $signed(NW'(sq_last.root));
    n1   = -b_w - s_w;
    n2   = -b_w + s_w;
    m1   = n1[NW-1] ? NMAG'(-n1) : NMAG'(n1);
    m2   = n2[NW-1] ? NMAG'(-n2) : NMAG'(n2);
    sm1  = MAGW'(m1) << FRAC;
    sm2  = MAGW'(m2) << FRAC;
    den  = {sq_last.a, 1'b0};
    ovf1 = DENW'(sm1[MAGW-1:QW]) >= den;
    ovf2 = DENW'(sm2[MAGW-1:QW]) >= den;
  end

  logic  p_v_r;
  div_t  pe_r, px_r;
  side_t side_r [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= sq_v[SQW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pe_r.num <= sm1[QW-1:0];
      pe_r.rem <= DREMW'(sm1[MAGW-1:QW]);
      pe_r.den <= den;
      pe_r.q   <= '0;
      px_r.num <= sm2[QW-1:0];
      px_r.rem <= DREMW'(sm2[MAGW-1:QW]);
      px_r.den <= den;
      px_r.q   <= '0;
      side_r[0] <= '{hit: sq_last.hit, org_in: sq_last.org_in, zdir: sq_last.zdir,
                     neg_e: n1[NW-1], neg_x: n2[NW-1], ovf_e: ovf1, ovf_x: ovf2};
      for (int k = 1; k <= QW; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // division chains, near and far distance side by side
  logic de_v [QW+1];
  logic dx_v [QW+1];
  div_t de_d [QW+1];
  div_t dx_d [QW+1];

  assign de_v[0] = p_v_r;
  assign dx_v[0] = p_v_r;
  assign de_d[0] = pe_r;
  assign dx_d[0] = px_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    rsi_div_cell u_enter (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (de_v[k]),
      .d_i   (de_d[k]),
      .vld_o (de_v[k+1]),
      .d_o   (de_d[k+1])
    );
    rsi_div_cell u_exit (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (dx_v[k]),
      .d_i   (dx_d[k]),
      .vld_o (dx_v[k+1]),
      .d_o   (dx_d[k+1])
    );
  end

  // sign, saturation and miss handling into the output register
  side_t     fin;
  logic [CW:0] ce, cx;
  out_word_t out_nxt;
  logic      out_valid_r;
  out_word_t out_word_r;

  assign fin = side_r[QW];
  assign ce  = clip(de_d[QW].q, fin.neg_e, fin.ovf_e);
  assign cx  = clip(dx_d[QW].q, fin.neg_x, fin.ovf_x);

  always_comb begin
    out_nxt.hit            = fin.hit;
    out_nxt.enter_distance = fin.hit ? ce[CW-1:0] : '0;
    out_nxt.exit_distance  = fin.hit ? cx[CW-1:0] : '0;
    out_nxt.origin_inside  = fin.org_in;
    out_nxt.zero_direction = fin.zdir;
    out_nxt.saturated      = fin.hit && (ce[CW] || cx[CW]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= de_v[QW] && dx_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: rtl/rsi_checker.sv
// rsi_checker: port-level assertions for ray_sphere_intersect, bound to the top
// depends on rsi_pkg
module rsi_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input rsi_pkg::in_word_t      in_word,
  input logic                   out_valid,
  input logic                   out_ready,
  input rsi_pkg::out_word_t     out_word,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [1:0]             cfg_index,
  input logic [rsi_pkg::CW-1:0] cfg_data
);
  import rsi_pkg::*;

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // a zero direction never hits
  a_zdir_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.zero_direction |-> !out_word.hit)
    else $error("hit with zero direction");

  // a miss reports zero distances and no saturation
  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.hit |->
      out_word.enter_distance == '0 && out_word.exit_distance == '0 &&
      !out_word.saturated)
    else $error("miss with nonzero distance or saturation");

  // near root never lies beyond far root
  a_root_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.hit |-> out_word.enter_distance <= out_word.exit_distance)
    else $error("enter distance beyond exit distance");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);

// File: tb/ray_sphere_intersect_test.sv
// ray_sphere_intersect_test: self-checking bench for the ray / sphere intersection pipeline
// depends on rsi_pkg and ray_sphere_intersect; an exact wide-integer predictor runs inside
// a small scoreboard class; tasks drive rays and registers, an always block out_ready
module ray_sphere_intersect_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rsi_pkg::*;

  typedef logic signed [255:0] wide_t;

  // scoreboard: holds the sphere registers, predicts one result word per ray
  class sphere_scoreboard;
    logic signed [CW-1:0] center[3];
    logic [RW-1:0]        radius;
    out_word_t            pending_q[$];
    int                   errors, checked, hits, sats, insides, zdirs;

    function new();
      center = '{0, 0, 0};
      radius = 65536;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CW-1:0] data);
      if (idx == REG_RADIUS) radius = data[RW-1:0];
      else center[idx] = data;
    endfunction

    function wide_t root_floor(wide_t v);
      wide_t r, c;
      r = 0;
      for (int k = 119; k >= 0; k--) begin
        c = r | (wide_t'(1) <<< k);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    // (num << FRAC) / den, truncated toward zero, clipped to the coordinate range
    function logic [CW-1:0] scaled_ratio(wide_t num, wide_t den, ref logic sat);
      wide_t mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag <<< FRAC) / den;
      if (num < 0) q = -q;
      if (q > wide_t'(32'sh7fffffff)) begin
        q = 32'sh7fffffff;
        sat = 1;
      end
      if (q < wide_t'(-64'sh80000000)) begin
        q = -64'sh80000000;
        sat = 1;
      end
      return q[CW-1:0];
    endfunction

    function void note_ray(in_word_t w);
      wide_t o[3], d[3], oc, a, dot, occ, b, c, rr, disc, s;
      out_word_t e;
      logic sat;
      o = '{w.origin_x, w.origin_y, w.origin_z};
      d = '{w.dir_x, w.dir_y, w.dir_z};
      a = 0; dot = 0; occ = 0; sat = 0;
      for (int i = 0; i < 3; i++) begin
        oc = o[i] - wide_t'(center[i]);
        a += d[i] * d[i];
        dot += oc * d[i];
        occ += oc * oc;
      end
      b = dot + dot;
      rr = wide_t'({1'b0, radius}) * wide_t'({1'b0, radius});
      c = occ - rr;
      disc = b * b - 4 * a * c;
      e = '0;
      e.origin_inside = (c <= 0);
      e.zero_direction = (a == 0);
      if (a != 0 && disc >= 0) begin
        s = root_floor(disc);
        e.hit = 1;
        e.enter_distance = scaled_ratio(-b - s, a + a, sat);
        e.exit_distance = scaled_ratio(-b + s, a + a, sat);
        e.saturated = sat;
      end
      hits += e.hit;
      sats += e.saturated;
      insides += e.origin_inside;
      zdirs += e.zero_direction;
      pending_q.push_back(e);
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      checked++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h", $time, got);
        return;
      end
      e = pending_q.pop_front();
      if (got.hit !== e.hit) begin
        errors++;
        $display("%0t: hit exp %b got %b", $time, e.hit, got.hit);
      end
      if (got.enter_distance !== e.enter_distance) begin
        errors++;
        $display("%0t: enter exp %h got %h", $time, e.enter_distance, got.enter_distance);
      end
      if (got.exit_distance !== e.exit_distance) begin
        errors++;
        $display("%0t: exit exp %h got %h", $time, e.exit_distance, got.exit_distance);
      end
      if (got.origin_inside !== e.origin_inside) begin
        errors++;
        $display("%0t: inside exp %b got %b", $time, e.origin_inside, got.origin_inside);
      end
      if (got.zero_direction !== e.zero_direction) begin
        errors++;
        $display("%0t: zero dir exp %b got %b", $time, e.zero_direction, got.zero_direction);
      end
      if (got.saturated !== e.saturated) begin
        errors++;
        $display("%0t: saturated exp %b got %b", $time, e.saturated, got.saturated);
      end
    endfunction
  endclass

  localparam int ONE = 65536;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [CW-1:0] cfg_data;
  in_word_t in_word;
  out_word_t out_word;

  sphere_scoreboard sb = new();
  bit calm;           // set for the closing stretch: no stalls on either side
  bit out_hold_mode;  // lets the receiver run in stall-free stretches too
  int cycles;

  ray_sphere_intersect u_dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_word,
    .out_valid, .out_ready, .out_word,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stall bursts, none once calm or in out_hold_mode
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_word);
    if (calm || out_hold_mode) begin
      out_ready <= 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // put one ray word on the input and hold it until it is taken; valid stays high
  task automatic send_ray(in_word_t w);
    in_valid <= 1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_ray(w);
  endtask

  // optional sender gap after a word
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // wait for every predicted word to come back
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // write all four sphere registers back to back, only while idle
  task automatic load_sphere(int cx, int cy, int cz, logic [CW-1:0] r);
    logic [CW-1:0] vals[4];
    logic [1:0] idx[4];
    vals = '{cx, cy, cz, r};
    idx = '{REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z, REG_RADIUS};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_valid <= 0;
  endtask

  function automatic in_word_t ray(int ox, int oy, int oz, int dx, int dy, int dz);
    in_word_t w;
    w = '{ox, oy, oz, dx, dy, dz};
    return w;
  endfunction

  function automatic int near_coord(int base, int span);
    return base + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // random ray: mostly aimed near the sphere, some noise and corner shapes
  function automatic in_word_t random_ray();
    in_word_t w;
    int sel, span;
    sel = $urandom_range(0, 11);
    span = 8 * ONE;
    w = ray(near_coord(sb.center[0], span), near_coord(sb.center[1], span),
            near_coord(sb.center[2], span), 0, 0, 0);
    case (sel)
      0, 1: w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      2: ;  // zero direction, random origin near the sphere
      3: begin
        // axis-aligned direction
        case ($urandom_range(0, 2))
          0: w.dir_x = $urandom;
          1: w.dir_y = $urandom;
          default: w.dir_z = $urandom;
        endcase
      end
      4: begin
        // tiny direction from an origin near the sphere drives the quotients out of range
        w.dir_x = $signed($urandom_range(0, 6)) - 3;
        w.dir_y = $signed($urandom_range(0, 6)) - 3;
        w.dir_z = $signed($urandom_range(0, 6)) - 3;
      end
      default: begin
        // aim back at the center with some jitter, x sometimes flipped
        w.dir_x = sb.center[0] - w.origin_x + near_coord(0, ONE);
        w.dir_y = sb.center[1] - w.origin_y + near_coord(0, ONE);
        w.dir_z = sb.center[2] - w.origin_z + near_coord(0, ONE);
        if ($urandom_range(0, 3) == 0) w.dir_x = -w.dir_x;
      end
    endcase
    return w;
  endfunction

  localparam int MAXC = 32'sh7fffffff;
  localparam int MINC = 32'sh80000000;

  initial begin
    int phase_rays;
    in_valid = 0;
    in_word = '0;
    cfg_valid = 0;
    cfg_index = REG_CENTER_X;
    cfg_data = '0;
    out_ready = 0;
    calm = 0;
    out_hold_mode = 0;
    cycles = 0;
    rst_n = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed words against the reset sphere (unit sphere at the origin)
    send_ray(ray(-4 * ONE, 0, 0, ONE, 0, 0));        // straight through the center
    send_ray(ray(-4 * ONE, 2 * ONE, 0, ONE, 0, 0));  // clean miss
    send_ray(ray(-4 * ONE, ONE, 0, ONE, 0, 0));      // grazing the surface
    send_ray(ray(0, 0, 0, 0, ONE, 0));               // origin at the center
    send_ray(ray(ONE, 0, 0, 0, 0, ONE));             // origin on the surface
    send_ray(ray(4 * ONE, 0, 0, ONE, 0, 0));         // sphere behind the ray
    send_ray(ray(ONE / 2, 0, 0, 0, 0, 0));           // zero direction, inside
    send_ray(ray(MAXC, MAXC, MAXC, 0, 0, 0));        // zero direction, far away
    send_ray(ray(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
    send_ray(ray(MINC, MINC, MINC, MINC, MINC, MINC));
    send_ray(ray(MAXC, MINC, MAXC, MINC, MAXC, MINC));
    send_ray(ray(-100 * ONE, 0, 0, 1, 0, 0));        // tiny direction: saturated
    send_ray(ray(100 * ONE, 0, 0, -1, 0, 0));
    send_ray(ray(0, 0, -3 * ONE, 0, 0, MINC));
    send_ray(ray(0, 0, 0, 1, 1, 1));
    drain();

    // sphere corner cases, then random phases with different spheres
    load_sphere(MAXC, MINC, MAXC, 32'h7fffffff);
    send_ray(ray(MINC, MAXC, MINC, MAXC, MINC, MAXC));
    send_ray(ray(0, 0, 0, ONE, 0, 0));
    drain();
    load_sphere(0, 0, 0, 0);  // radius zero: only exact aims hit
    send_ray(ray(-ONE, 0, 0, ONE, 0, 0));
    send_ray(ray(0, 0, 0, ONE, 0, 0));
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: load_sphere(0, 0, 0, ONE);
        1: load_sphere(3 * ONE, -2 * ONE, ONE / 3, 3 * ONE + ONE / 2);
        2: load_sphere(MAXC, MAXC, MAXC, 32'h7fffffff);
        3: load_sphere(MINC, MINC, MINC, 0);
        4: load_sphere($urandom, $urandom, $urandom, $urandom);
        5: load_sphere(-50 * ONE, 10 * ONE, 7 * ONE, 100 * ONE);
        default: load_sphere(ONE, ONE, ONE, 2 * ONE);
      endcase
      out_hold_mode = (ph == 1);
      calm = (ph == 6);
      phase_rays = (ph == 6) ? 200 : 260;
      for (int i = 0; i < phase_rays; i++) begin
        send_ray(random_ray());
        if (ph == 3 && i == 100) drain();  // hold the sender until all words are back
        else if (ph != 5) maybe_gap();
      end
      drain();
    end

    repeat (150) @(posedge clk);
    $display("checked %0d result words: %0d hits, %0d saturated, %0d inside, %0d zero dir",
             sb.checked, sb.hits, sb.sats, sb.insides, sb.zdirs);
    $display("spheres covered: reset, extreme centers and radii, random and offset");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
